>>> hw/rtl/sorted_deadline_timer_queue_assert.svh
// Assertion macros shared by the timer queue RTL.
// Depends on nothing; included by modules that check their own logic.
`ifndef SORTED_DEADLINE_TIMER_QUEUE_ASSERT_SVH
`define SORTED_DEADLINE_TIMER_QUEUE_ASSERT_SVH
// implication checked on every clock, quiet in reset
`define SDTQ_ASSERT_IMP(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
// next-cycle implication
`define SDTQ_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

>>> hw/rtl/sdtq_pkg.sv
// Package for the timer queue: codes, widths and shared types.
// No dependencies.
package sdtq_pkg;
	localparam int CAPACITY_DEF = 32;
	localparam logic [30:0] DEADLINE_MAX_DEF = 31'h7fffffff;
	localparam int ID_W = 5;
	localparam int DL_W = 31;
	localparam int QDEPTH = 2;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_ADJUST = 2'd1,
		OP_DELETE = 2'd2,
		OP_TICK   = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_ABSENT  = 3'd1,
		ST_DUP     = 3'd2,
		ST_FULL    = 3'd3,
		ST_BADDL   = 3'd4,
		ST_EXPIRED = 3'd5,
		ST_DONE    = 3'd6
	} status_t;

	// classified command from front to back
	typedef struct packed {
		opcode_t          op;
		logic [ID_W-1:0]  id;
		logic [DL_W-1:0]  dl;
		logic [DL_W-1:0]  now;
		logic             present;
		logic             dl_bad;
	} cmd_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SCAN,
		BK_REMOVE,
		BK_FIND,
		BK_INSERT,
		BK_EMIT,
		BK_EXPIRE
	} bk_state_t;
endpackage

>>> hw/rtl/sdtq_in_if.sv
// Input channel interface of the timer queue.
// Depends on sdtq_pkg.
interface sdtq_in_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 opcode;
	logic [sdtq_pkg::ID_W-1:0]  timer_id;
	logic [sdtq_pkg::DL_W-1:0]  deadline;
	logic [sdtq_pkg::DL_W-1:0]  current_time;
	modport source (output valid, opcode, timer_id, deadline, current_time, input ready);
	modport sink (input valid, opcode, timer_id, deadline, current_time, output ready);
endinterface

>>> hw/rtl/sdtq_out_if.sv
// Result channel interface of the timer queue.
// Depends on sdtq_pkg.
interface sdtq_out_if;
	logic                       valid;
	logic                       ready;
	logic [2:0]                 status;
	logic [sdtq_pkg::ID_W-1:0]  expired_id;
	logic                       last;
	modport source (output valid, status, expired_id, last, input ready);
	modport sink (input valid, status, expired_id, last, output ready);
endinterface

>>> hw/rtl/sdtq_front.sv
// Front end: accept commands, keep the queued flags, classify, push to a short queue.
// Depends on sdtq_pkg and the assertion header.
`include "sorted_deadline_timer_queue_assert.svh"
module sdtq_front #(
	parameter logic [sdtq_pkg::DL_W-1:0] DEADLINE_MAX = sdtq_pkg::DEADLINE_MAX_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	sdtq_in_if.sink                   in_ch,
	output logic                      cmd_valid,
	output sdtq_pkg::cmd_t            cmd,
	input  logic                      cmd_pop,
	input  logic                      back_busy,
	input  logic                      clr_en,
	input  logic [sdtq_pkg::ID_W-1:0] clr_id,
	input  logic                      set_en,
	input  logic [sdtq_pkg::ID_W-1:0] set_id
);
	localparam int PW = $clog2(sdtq_pkg::QDEPTH);
	sdtq_pkg::cmd_t fifo_q [sdtq_pkg::QDEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW:0]   cnt_q;
	logic [31:0]   flags_q;
	logic          acc;
	sdtq_pkg::cmd_t nc;

	// one command in flight keeps flags exact at classification
	assign in_ch.ready = (cnt_q == '0) && !back_busy;
	assign acc = in_ch.valid && in_ch.ready;

	// classify the incoming beat
	always_comb begin
		nc.op      = sdtq_pkg::opcode_t'(in_ch.opcode);
		nc.id      = in_ch.timer_id;
		nc.dl      = in_ch.deadline;
		nc.now     = in_ch.current_time;
		nc.present = flags_q[in_ch.timer_id];
		nc.dl_bad  = in_ch.deadline >= DEADLINE_MAX;
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (acc) fifo_q[wr_q] <= nc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (acc) wr_q <= wr_q + 1'b1;
			if (cmd_pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(acc) - (PW+1)'(cmd_pop);
		end
	end

	// track queued ids from back-end updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else begin
			if (clr_en) flags_q[clr_id] <= 1'b0;
			if (set_en) flags_q[set_id] <= 1'b1;
		end
	end

	assign cmd_valid = cnt_q != '0;
	assign cmd = fifo_q[rd_q];

	`SDTQ_ASSERT_IMP(a_pop_nonempty, clk, arst_n, cmd_pop, cnt_q != '0)
	`SDTQ_ASSERT_IMP(a_no_overflow, clk, arst_n, acc, cnt_q < (PW+1)'(sdtq_pkg::QDEPTH))
	`SDTQ_ASSERT_IMP(a_set_clr_diff, clk, arst_n, set_en && clr_en, set_id != clr_id)
endmodule

>>> hw/rtl/sdtq_back.sv
// Back end: sorted slot store and a sequencer for add, adjust, delete and tick.
// Depends on sdtq_pkg and the assertion header.
`include "sorted_deadline_timer_queue_assert.svh"
module sdtq_back #(
	parameter int CAPACITY = sdtq_pkg::CAPACITY_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cmd_valid,
	input  sdtq_pkg::cmd_t            cmd,
	output logic                      cmd_pop,
	output logic                      busy,
	output logic                      clr_en,
	output logic [sdtq_pkg::ID_W-1:0] clr_id,
	output logic                      set_en,
	output logic [sdtq_pkg::ID_W-1:0] set_id,
	sdtq_out_if.source                out_ch
);
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP = CW'(CAPACITY);

	// slot store: shift register, the head always in slot 0
	logic [sdtq_pkg::ID_W-1:0] ids_q [CAPACITY];
	logic [sdtq_pkg::DL_W-1:0] dls_q [CAPACITY];
	logic [CW-1:0] occ_q, ptr_q;
	sdtq_pkg::bk_state_t st_q, st_d;
	sdtq_pkg::cmd_t cmd_q;
	logic [2:0] res_st_q;
	logic [2:0] ost_q;
	logic [sdtq_pkg::ID_W-1:0] oid_q;
	logic olast_q, ovalid_q;
	logic oslot_free;
	logic [AW-1:0] pa;
	logic head_due;
	logic do_pop, do_rm, do_ins, do_exp;

	assign oslot_free = !ovalid_q || out_ch.ready;
	assign pa = ptr_q[AW-1:0];
	assign head_due = (occ_q != '0) && (cmd_q.now >= dls_q[0]);

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			sdtq_pkg::BK_IDLE: if (cmd_valid) st_d = sdtq_pkg::BK_SCAN;
			sdtq_pkg::BK_SCAN: begin
				case (cmd_q.op)
					sdtq_pkg::OP_TICK: st_d = sdtq_pkg::BK_EXPIRE;
					sdtq_pkg::OP_ADD:
						st_d = (!cmd_q.present && !cmd_q.dl_bad && occ_q < CAP)
							? sdtq_pkg::BK_INSERT : sdtq_pkg::BK_EMIT;
					default:
						st_d = (cmd_q.present && !(cmd_q.op == sdtq_pkg::OP_ADJUST
							&& cmd_q.dl_bad)) ? sdtq_pkg::BK_FIND : sdtq_pkg::BK_EMIT;
				endcase
			end
			sdtq_pkg::BK_FIND: if (ids_q[pa] == cmd_q.id) st_d = sdtq_pkg::BK_REMOVE;
			sdtq_pkg::BK_REMOVE:
				st_d = (cmd_q.op == sdtq_pkg::OP_ADJUST) ? sdtq_pkg::BK_INSERT
					: sdtq_pkg::BK_EMIT;
			sdtq_pkg::BK_INSERT:
				if (ptr_q == occ_q || dls_q[pa] > cmd_q.dl) st_d = sdtq_pkg::BK_EMIT;
			sdtq_pkg::BK_EMIT: if (oslot_free) st_d = sdtq_pkg::BK_IDLE;
			sdtq_pkg::BK_EXPIRE: if (oslot_free && !head_due) st_d = sdtq_pkg::BK_IDLE;
			default: st_d = sdtq_pkg::BK_IDLE;
		endcase
	end

	// actions
	always_comb begin
		do_pop = st_q == sdtq_pkg::BK_IDLE && cmd_valid;
		do_rm  = st_q == sdtq_pkg::BK_REMOVE;
		do_ins = st_q == sdtq_pkg::BK_INSERT && (ptr_q == occ_q || dls_q[pa] > cmd_q.dl);
		do_exp = st_q == sdtq_pkg::BK_EXPIRE && oslot_free && head_due;
		cmd_pop = do_pop;
		busy = st_q != sdtq_pkg::BK_IDLE;
		clr_en = do_rm || do_exp;
		clr_id = do_exp ? ids_q[0] : cmd_q.id;
		set_en = do_ins;
		set_id = cmd_q.id;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= sdtq_pkg::BK_IDLE;
		else st_q <= st_d;
	end

	// occupancy, scan pointer, result code; the command is latched below
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
			ptr_q <= '0;
			res_st_q <= sdtq_pkg::ST_OK;
		end else begin
			if (do_pop) ptr_q <= '0;
			if (st_q == sdtq_pkg::BK_SCAN) begin
				ptr_q <= '0;
				if (cmd_q.op == sdtq_pkg::OP_ADD) begin
					if (cmd_q.present) res_st_q <= sdtq_pkg::ST_DUP;
					else if (cmd_q.dl_bad) res_st_q <= sdtq_pkg::ST_BADDL;
					else if (occ_q >= CAP) res_st_q <= sdtq_pkg::ST_FULL;
					else res_st_q <= sdtq_pkg::ST_OK;
				end else if (!cmd_q.present) res_st_q <= sdtq_pkg::ST_ABSENT;
				else if (cmd_q.op == sdtq_pkg::OP_ADJUST && cmd_q.dl_bad)
					res_st_q <= sdtq_pkg::ST_BADDL;
				else res_st_q <= sdtq_pkg::ST_OK;
			end
			if (st_q == sdtq_pkg::BK_FIND && ids_q[pa] != cmd_q.id) ptr_q <= ptr_q + 1'b1;
			if (do_rm) begin
				occ_q <= occ_q - 1'b1;
				ptr_q <= '0;
			end
			if (st_q == sdtq_pkg::BK_INSERT && !do_ins) ptr_q <= ptr_q + 1'b1;
			if (do_ins) occ_q <= occ_q + 1'b1;
			if (do_exp) occ_q <= occ_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_pop) cmd_q <= cmd;
	end

	// shift slots: close a gap on remove, open one on insert, drop the head on expire
	always_ff @(posedge clk) begin
		for (int i = 0; i < CAPACITY; i++) begin
			if ((do_rm && CW'(i) >= ptr_q) || do_exp) begin
				if (i + 1 < CAPACITY) begin
					ids_q[i] <= ids_q[(i + 1) % CAPACITY];
					dls_q[i] <= dls_q[(i + 1) % CAPACITY];
				end
			end else if (do_ins) begin
				if (CW'(i) == ptr_q) begin
					ids_q[i] <= cmd_q.id;
					dls_q[i] <= cmd_q.dl;
				end else if (CW'(i) > ptr_q && i > 0) begin
					ids_q[i] <= ids_q[(i + CAPACITY - 1) % CAPACITY];
					dls_q[i] <= dls_q[(i + CAPACITY - 1) % CAPACITY];
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (oslot_free) begin
			ovalid_q <= (st_q == sdtq_pkg::BK_EMIT) || (st_q == sdtq_pkg::BK_EXPIRE);
		end
	end

	always_ff @(posedge clk) begin
		if (oslot_free) begin
			if (st_q == sdtq_pkg::BK_EXPIRE) begin
				ost_q   <= head_due ? sdtq_pkg::ST_EXPIRED : sdtq_pkg::ST_DONE;
				oid_q   <= head_due ? ids_q[0] : '0;
				olast_q <= !head_due;
			end else begin
				ost_q   <= res_st_q;
				oid_q   <= cmd_q.id;
				olast_q <= 1'b1;
			end
		end
	end

	assign out_ch.valid = ovalid_q;
	assign out_ch.status = ost_q;
	assign out_ch.expired_id = oid_q;
	assign out_ch.last = olast_q;

	`SDTQ_ASSERT_IMP(a_occ_bound, clk, arst_n, 1'b1, occ_q <= CAP)
	`SDTQ_ASSERT_IMP(a_find_in_range, clk, arst_n, st_q == sdtq_pkg::BK_FIND, ptr_q < occ_q)
	`SDTQ_ASSERT_NEXT(a_ins_grows, clk, arst_n, do_ins, occ_q == $past(occ_q) + 1'b1)
endmodule

>>> hw/rtl/sorted_deadline_timer_queue.sv
// Top level of the sorted deadline timer queue.
// Depends on sdtq_pkg, sdtq_in_if, sdtq_out_if, sdtq_front and sdtq_back.
//
// Keeps up to CAPACITY timers sorted by deadline, equal deadlines in arrival
// order. One command is in work at a time. After acceptance a command passes
// the front queue, is latched and is classified in the scan state; add then
// walks to its insert position, delete walks to its slot and removes it, and
// adjust removes it and walks to its new insert position, before the result
// beat is loaded. A tick loads one beat per expired timer, then a done beat.
// Every result beat also waits while the previous beat is held by the receiver.
// The scan over slots steps one slot per cycle. The next command is accepted
// once the back end has loaded the final beat of the current one.
module sorted_deadline_timer_queue #(
	parameter int CAPACITY = sdtq_pkg::CAPACITY_DEF,
	parameter logic [sdtq_pkg::DL_W-1:0] DEADLINE_MAX = sdtq_pkg::DEADLINE_MAX_DEF
) (
	input logic        clk,
	input logic        arst_n,
	sdtq_in_if.sink    in_ch,
	sdtq_out_if.source out_ch
);
	logic cmd_valid, cmd_pop, busy, clr_en, set_en;
	sdtq_pkg::cmd_t cmd;
	logic [sdtq_pkg::ID_W-1:0] clr_id, set_id;

	sdtq_front #(.DEADLINE_MAX(DEADLINE_MAX)) u_front (
		.clk, .arst_n, .in_ch, .cmd_valid, .cmd, .cmd_pop,
		.back_busy(busy), .clr_en, .clr_id, .set_en, .set_id
	);

	sdtq_back #(.CAPACITY(CAPACITY)) u_back (
		.clk, .arst_n, .cmd_valid, .cmd, .cmd_pop, .busy,
		.clr_en, .clr_id, .set_en, .set_id, .out_ch
	);
endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for sorted_deadline_timer_queue: directed and random timer commands.
// Depends on sdtq_pkg, sdtq_in_if, sdtq_out_if and the timer queue RTL.
module tb;
	localparam int ID_W = sdtq_pkg::ID_W;
	localparam int DL_W = sdtq_pkg::DL_W;
	localparam int SLOTS = sdtq_pkg::CAPACITY_DEF;
	localparam logic [DL_W-1:0] DL_LIMIT = sdtq_pkg::DEADLINE_MAX_DEF;
	localparam int WATCHDOG_CYCLES = 4000;

	typedef struct {
		sdtq_pkg::opcode_t op;
		logic [ID_W-1:0]   id;
		logic [DL_W-1:0]   dl;
		logic [DL_W-1:0]   now;
	} cmd_beat_t;

	typedef struct {
		sdtq_pkg::status_t status;
		logic [ID_W-1:0]   id;
		logic              last;
	} result_beat_t;

	logic clk = 1'b0;
	logic arst_n;

	sdtq_in_if  in_if ();
	sdtq_out_if out_if ();

	sorted_deadline_timer_queue u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_if.sink),
		.out_ch (out_if.source)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// timer list as the bench sees it
	logic [ID_W-1:0] list_ids [SLOTS];
	logic [DL_W-1:0] list_dls [SLOTS];
	int              list_count;
	logic [31:0]     armed;

	cmd_beat_t    cmd_queue[$];
	result_beat_t expected_results[$];
	int           errors;
	logic         quiet;
	logic         long_hold_req;
	logic         long_hold_done;
	int           hold_left;
	int           stall_left;
	int           gap_left;
	int           idle_cycles;

	function automatic void push_result(sdtq_pkg::status_t st, logic [ID_W-1:0] id,
			logic last);
		result_beat_t r;
		r.status = st;
		r.id     = id;
		r.last   = last;
		expected_results.push_back(r);
	endfunction

	function automatic void unlink_slot(int pos);
		armed[list_ids[pos]] = 1'b0;
		for (int i = pos; i + 1 < list_count; i++) begin
			list_ids[i] = list_ids[i + 1];
			list_dls[i] = list_dls[i + 1];
		end
		list_count--;
	endfunction

	// insert behind all equal deadlines
	function automatic void link_sorted(logic [ID_W-1:0] id, logic [DL_W-1:0] dl);
		int pos;
		pos = 0;
		while (pos < list_count && list_dls[pos] <= dl)
			pos++;
		for (int i = list_count; i > pos; i--) begin
			list_ids[i] = list_ids[i - 1];
			list_dls[i] = list_dls[i - 1];
		end
		list_ids[pos] = id;
		list_dls[pos] = dl;
		list_count++;
		armed[id] = 1'b1;
	endfunction

	function automatic int slot_of(logic [ID_W-1:0] id);
		for (int i = 0; i < list_count; i++)
			if (list_ids[i] == id)
				return i;
		return list_count;
	endfunction

	// work out the result beats of one accepted command
	function automatic void predict_timer_results(sdtq_pkg::opcode_t op,
			logic [ID_W-1:0] id, logic [DL_W-1:0] dl, logic [DL_W-1:0] now);
		logic present;
		int   n;
		present = armed[id];
		case (op)
			sdtq_pkg::OP_ADD: begin
				if (present)
					push_result(sdtq_pkg::ST_DUP, id, 1'b1);
				else if (dl >= DL_LIMIT)
					push_result(sdtq_pkg::ST_BADDL, id, 1'b1);
				else if (list_count >= SLOTS)
					push_result(sdtq_pkg::ST_FULL, id, 1'b1);
				else begin
					link_sorted(id, dl);
					push_result(sdtq_pkg::ST_OK, id, 1'b1);
				end
			end
			sdtq_pkg::OP_ADJUST: begin
				if (!present)
					push_result(sdtq_pkg::ST_ABSENT, id, 1'b1);
				else if (dl >= DL_LIMIT)
					push_result(sdtq_pkg::ST_BADDL, id, 1'b1);
				else begin
					unlink_slot(slot_of(id));
					link_sorted(id, dl);
					push_result(sdtq_pkg::ST_OK, id, 1'b1);
				end
			end
			sdtq_pkg::OP_DELETE: begin
				if (!present)
					push_result(sdtq_pkg::ST_ABSENT, id, 1'b1);
				else begin
					unlink_slot(slot_of(id));
					push_result(sdtq_pkg::ST_OK, id, 1'b1);
				end
			end
			default: begin
				n = 0;
				while (n < list_count && now >= list_dls[n]) begin
					push_result(sdtq_pkg::ST_EXPIRED, list_ids[n], 1'b0);
					armed[list_ids[n]] = 1'b0;
					n++;
				end
				for (int i = n; i < list_count; i++) begin
					list_ids[i - n] = list_ids[i];
					list_dls[i - n] = list_dls[i];
				end
				list_count -= n;
				push_result(sdtq_pkg::ST_DONE, '0, 1'b1);
			end
		endcase
	endfunction

	// hold all inputs at known values from time zero
	initial begin
		in_if.valid        = 1'b0;
		in_if.opcode       = '0;
		in_if.timer_id     = '0;
		in_if.deadline     = '0;
		in_if.current_time = '0;
		out_if.ready       = 1'b0;
	end

	// command driver: offer queued beats, idle in random bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_if.valid <= 1'b0;
			gap_left    <= 0;
		end else begin
			if (in_if.valid && in_if.ready)
				predict_timer_results(sdtq_pkg::opcode_t'(in_if.opcode), in_if.timer_id,
					in_if.deadline, in_if.current_time);
			if (!in_if.valid || in_if.ready) begin
				if (gap_left > 0) begin
					in_if.valid <= 1'b0;
					gap_left    <= gap_left - 1;
				end else if (cmd_queue.size() > 0) begin
					cmd_beat_t c;
					c = cmd_queue.pop_front();
					in_if.valid        <= 1'b1;
					in_if.opcode       <= c.op;
					in_if.timer_id     <= c.id;
					in_if.deadline     <= c.dl;
					in_if.current_time <= c.now;
					if (!quiet && $urandom_range(0, 7) == 0)
						gap_left <= int'($urandom_range(1, 18));
				end else begin
					in_if.valid <= 1'b0;
				end
			end
		end
	end

	// result ready: one long hold-off on request, else short random stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_if.ready   <= 1'b0;
			hold_left      <= 0;
			stall_left     <= 0;
			long_hold_done <= 1'b0;
		end else if (hold_left > 0) begin
			out_if.ready <= 1'b0;
			hold_left    <= hold_left - 1;
		end else if (long_hold_req && !long_hold_done) begin
			out_if.ready   <= 1'b0;
			hold_left      <= 400;
			long_hold_done <= 1'b1;
		end else if (stall_left > 0) begin
			out_if.ready <= 1'b0;
			stall_left   <= stall_left - 1;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			out_if.ready <= 1'b0;
			stall_left   <= int'($urandom_range(0, 17));
		end else begin
			out_if.ready <= 1'b1;
		end
	end

	// compare each result beat with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_if.valid && out_if.ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected beat status=%0d id=%0d last=%0b", $time,
					out_if.status, out_if.expired_id, out_if.last);
				errors++;
			end else begin
				result_beat_t e;
				e = expected_results.pop_front();
				if (out_if.status !== e.status) begin
					$display("%0t: status expected %0d actual %0d", $time, e.status,
						out_if.status);
					errors++;
				end
				if (out_if.expired_id !== e.id) begin
					$display("%0t: expired_id expected %0d actual %0d", $time, e.id,
						out_if.expired_id);
					errors++;
				end
				if (out_if.last !== e.last) begin
					$display("%0t: last expected %0b actual %0b", $time, e.last,
						out_if.last);
					errors++;
				end
			end
		end
	end

	// end the run when no beat moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
			idle_cycles <= 0;
		else if (idle_cycles >= WATCHDOG_CYCLES) begin
			$display("TB_ERROR");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	task automatic queue_cmd(sdtq_pkg::opcode_t op, logic [ID_W-1:0] id,
			logic [DL_W-1:0] dl, logic [DL_W-1:0] now);
		cmd_beat_t c;
		c.op  = op;
		c.id  = id;
		c.dl  = dl;
		c.now = now;
		cmd_queue.push_back(c);
	endtask

	// pause the sender until every expected beat is back
	task automatic wait_drained();
		while (cmd_queue.size() > 0 || in_if.valid || expected_results.size() > 0)
			@(negedge clk);
	endtask

	task automatic queue_random(int count, ref logic [DL_W-1:0] clock_now);
		int                pick;
		sdtq_pkg::opcode_t op;
		logic [DL_W-1:0]   dl;
		logic [DL_W-1:0]   now;
		for (int k = 0; k < count; k++) begin
			pick = $urandom_range(0, 99);
			op = pick < 40 ? sdtq_pkg::OP_ADD : pick < 55 ? sdtq_pkg::OP_ADJUST
				: pick < 70 ? sdtq_pkg::OP_DELETE : sdtq_pkg::OP_TICK;
			pick = $urandom_range(0, 19);
			if (pick == 0)
				dl = DL_LIMIT;
			else if (pick == 1)
				dl = DL_LIMIT - 31'd1;
			else if (pick == 2)
				dl = DL_W'($urandom());
			else
				dl = DL_W'(clock_now + $urandom_range(0, 150));
			if (op == sdtq_pkg::OP_TICK) begin
				if ($urandom_range(0, 24) == 0)
					now = DL_W'($urandom());
				else begin
					clock_now = DL_W'(clock_now + $urandom_range(0, 60));
					now = clock_now;
				end
			end else begin
				now = DL_W'($urandom());
			end
			queue_cmd(op, ID_W'($urandom_range(0, 31)), dl, now);
		end
	endtask

	initial begin
		logic [DL_W-1:0] clock_now;
		errors        = 0;
		quiet         = 1'b0;
		long_hold_req = 1'b0;
		list_count    = 0;
		armed         = '0;
		arst_n        = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: edges of fields, every command, each corner
		queue_cmd(sdtq_pkg::OP_TICK, 5'd3, '0, '0);             // tick on empty list
		queue_cmd(sdtq_pkg::OP_ADD, 5'd0, 31'd10, '1);
		queue_cmd(sdtq_pkg::OP_ADD, 5'd31, 31'd10, '0);         // equal deadline, arrival order
		queue_cmd(sdtq_pkg::OP_ADD, 5'd0, 31'd50, '0);          // already queued
		queue_cmd(sdtq_pkg::OP_ADD, 5'd5, DL_LIMIT, '0);        // deadline rejected
		queue_cmd(sdtq_pkg::OP_ADD, 5'd6, DL_LIMIT - 31'd1, '0); // largest legal deadline
		queue_cmd(sdtq_pkg::OP_ADD, 5'd7, 31'd0, '0);
		queue_cmd(sdtq_pkg::OP_ADJUST, 5'd9, 31'd20, '0);       // absent
		queue_cmd(sdtq_pkg::OP_ADJUST, 5'd9, DL_LIMIT, '0);     // absent reported first
		queue_cmd(sdtq_pkg::OP_ADJUST, 5'd0, DL_LIMIT, '0);     // bad deadline on queued id
		queue_cmd(sdtq_pkg::OP_ADJUST, 5'd0, 31'd10, '0);       // re-enter behind equal deadline
		queue_cmd(sdtq_pkg::OP_DELETE, 5'd8, '1, '0);           // absent
		queue_cmd(sdtq_pkg::OP_TICK, 5'd0, '0, '0);             // expires only deadline zero
		queue_cmd(sdtq_pkg::OP_TICK, 5'd0, '0, 31'd9);          // nothing due
		queue_cmd(sdtq_pkg::OP_TICK, 5'd0, '0, 31'd10);         // expires 31 then 0
		queue_cmd(sdtq_pkg::OP_DELETE, 5'd6, '0, '0);
		queue_cmd(sdtq_pkg::OP_DELETE, 5'd6, '0, '0);
		queue_cmd(sdtq_pkg::OP_TICK, 5'd0, '0, '1);
		wait_drained();

		// fill all slots while results are held back, then expire all at once
		long_hold_req = 1'b1;
		for (int i = 0; i < SLOTS; i++)
			queue_cmd(sdtq_pkg::OP_ADD, ID_W'(i), DL_W'(1000 + $urandom_range(0, 40)),
				DL_W'($urandom()));
		queue_cmd(sdtq_pkg::OP_ADD, 5'd17, 31'd5, '0);
		queue_cmd(sdtq_pkg::OP_TICK, 5'd0, '0, DL_LIMIT);
		wait_drained();

		// random traffic around a moving clock
		clock_now = 31'd1000;
		queue_random(25, clock_now);
		wait_drained();
		queue_random(25, clock_now);
		wait_drained();
		quiet = 1'b1;
		queue_random(10, clock_now);
		wait_drained();
		repeat (60) @(posedge clk);

		if (errors == 0 && expected_results.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
